// ----- sv/hqd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hqd_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [SampleW-1:0] SampleMask = 12'hfff;
  localparam logic [1:0] LevelA = 2'h1;
  localparam logic [1:0] LevelB = 2'h2;

  localparam logic [SampleW-1:0] HighThrReset = 12'd2048;
  localparam logic [SampleW-1:0] LowThrReset  = 12'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THR_A = 8'd0,
    CFG_LOW_THR_A  = 8'd1,
    CFG_HIGH_THR_B = 8'd2,
    CFG_LOW_THR_B  = 8'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // x4 quadrature step, indexed by {old phase, new phase}.
  localparam step_t QuadStep [16] = '{
    STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
    STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
    STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
    STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
  };

  typedef struct packed {
    logic [SampleW-1:0] high_a;
    logic [SampleW-1:0] low_a;
    logic [SampleW-1:0] high_b;
    logic [SampleW-1:0] low_b;
  } thr_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [CountW-1:0] pos_count;
    logic [CountW-1:0] edges_a;
    logic [CountW-1:0] edges_b;
    logic [CountW-1:0] bad_count;
    logic [CountW-1:0] edge_time;
  } dec_state_t;

endpackage

`default_nettype wire

// ----- sv/hqd_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hqd_step
  import hqd_pkg::*;
(
  input  wire logic               channel,
  input  wire logic [SampleW-1:0] sample,
  input  wire logic [CountW-1:0]  time_now,
  input  wire thr_t               thr,
  input  wire dec_state_t         cur,
  output dec_state_t              nxt,
  output logic                    edge_seen
);

  logic [1:0]         bit_sel;
  logic [SampleW-1:0] hi;
  logic [SampleW-1:0] lo;
  logic [1:0]         new_phase;
  step_t              step;

  always_comb begin
    bit_sel   = channel ? LevelB : LevelA;
    hi        = channel ? thr.high_b : thr.high_a;
    lo        = channel ? thr.low_b : thr.low_a;
    new_phase = cur.phase;
    edge_seen = 1'b0;
    // Schmitt trigger: each level only looks at the threshold for its state.
    if ((cur.phase & bit_sel) != 2'b00) begin
      if (sample < lo) begin
        new_phase = cur.phase & ~bit_sel;
        edge_seen = 1'b1;
      end
    end else begin
      if (sample > hi) begin
        new_phase = cur.phase | bit_sel;
        edge_seen = 1'b1;
      end
    end

    step = QuadStep[{cur.phase, new_phase}];
    nxt  = cur;
    if (edge_seen) begin
      nxt.phase     = new_phase;
      nxt.edge_time = time_now;
      if (channel) begin
        nxt.edges_b = cur.edges_b + 1'b1;
      end else begin
        nxt.edges_a = cur.edges_a + 1'b1;
      end
      case (step)
        STEP_UP:   nxt.pos_count = cur.pos_count + 1'b1;
        STEP_DOWN: nxt.pos_count = cur.pos_count - 1'b1;
        default:   nxt.bad_count = cur.bad_count + 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/hysteresis_quadrature_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake       Payload
// in_      input      valid / stall   channel, sample, time_now
// out_     output     valid / stall   position, phase_bits, edge_seen, edges_a,
//                                     edges_b, illegal_count, last_edge_time
// cfg_     input      valid / ready   index, data (threshold registers 0..3)
//
// One request per cycle sustained while the result is not stalled.
// The hysteresis compare, table lookup and counter update sit between the input
// register and the result register, and the decoder state advances as a request
// moves into the result register.
// A stalled result holds; one more request is taken into the input register.
// Synchronous reset restores thresholds to 2048/1024 and clears all counters.

module hysteresis_quadrature_decoder_core
  import hqd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_channel,
  input  wire logic [SampleW-1:0]  in_sample,
  input  wire logic [CountW-1:0]   in_time_now,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [CountW-1:0] out_position,
  output logic [1:0]               out_phase_bits,
  output logic                     out_edge_seen,
  output logic [CountW-1:0]        out_edges_a,
  output logic [CountW-1:0]        out_edges_b,
  output logic [CountW-1:0]        out_illegal_count,
  output logic [CountW-1:0]        out_last_edge_time,

  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [SampleW-1:0]  cfg_data
);

  thr_t               thr_r;
  dec_state_t         state_r;
  dec_state_t         state_nxt;
  logic               edge_nxt;

  logic               s1_valid_r;
  logic               s1_channel_r;
  logic [SampleW-1:0] s1_sample_r;
  logic [CountW-1:0]  s1_time_r;

  logic               out_valid_r;
  dec_state_t         out_r;
  logic               out_edge_r;

  logic               advance;
  logic               in_take;
  logic               update;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign update    = s1_valid_r && advance;
  assign cfg_ready = 1'b1;

  hqd_step u_step (
    .channel   (s1_channel_r),
    .sample    (s1_sample_r & SampleMask),
    .time_now  (s1_time_r),
    .thr       (thr_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .edge_seen (edge_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.high_a <= HighThrReset;
      thr_r.low_a  <= LowThrReset;
      thr_r.high_b <= HighThrReset;
      thr_r.low_b  <= LowThrReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HIGH_THR_A: thr_r.high_a <= cfg_data;
        CFG_LOW_THR_A:  thr_r.low_a  <= cfg_data;
        CFG_HIGH_THR_B: thr_r.high_b <= cfg_data;
        CFG_LOW_THR_B:  thr_r.low_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (update) begin
        state_r <= state_nxt;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_channel_r <= in_channel;
      s1_sample_r  <= in_sample;
      s1_time_r    <= in_time_now;
    end
    if (update) begin
      out_r      <= state_nxt;
      out_edge_r <= edge_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = signed'(out_r.pos_count);
  assign out_phase_bits     = out_r.phase;
  assign out_edge_seen      = out_edge_r;
  assign out_edges_a        = out_r.edges_a;
  assign out_edges_b        = out_r.edges_b;
  assign out_illegal_count  = out_r.bad_count;
  assign out_last_edge_time = out_r.edge_time;

  // A request that crosses no threshold leaves the decoder state alone.
  assert property (@(posedge clk) disable iff (!rst_n)
    (update && !edge_nxt) |=> $stable(state_r))
    else $error("state changed on a request without a level change");

  // Each level change bumps exactly one edge counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (update && edge_nxt) |=>
      (CountW'(state_r.edges_a + state_r.edges_b) ==
       CountW'($past(state_r.edges_a) + $past(state_r.edges_b) + 1'b1)))
    else $error("edge counters out of step with level change");

  // Only one level can move per sample, so no illegal step is ever counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bad_count == '0)
    else $error("illegal transition counted");

  // The input side only stalls when both stages hold a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hqd_pkg::*;

  localparam int unsigned NumRegs          = 4;
  localparam int unsigned NumSettings      = 6;
  localparam int unsigned RandomPerSetting = 210;
  localparam int unsigned WatchdogLimit    = 2000;
  localparam logic [SampleW-1:0] SampleMax = SampleMask;

  // Position step for {old levels, new levels}, x4 gray-code decoding.
  localparam int GrayStep [16] = '{
    0, 1, -1, 0,
    -1, 0, 0, 1,
    1, 0, 0, -1,
    0, -1, 1, 0
  };

  typedef struct {
    logic signed [CountW-1:0] position;
    logic [1:0]               phase_bits;
    logic                     edge_seen;
    logic [CountW-1:0]        edges_a;
    logic [CountW-1:0]        edges_b;
    logic [CountW-1:0]        illegal_count;
    logic [CountW-1:0]        last_edge_time;
  } decoder_result_t;

  class decoder_scoreboard;
    logic [SampleW-1:0]       rise_thr[2];
    logic [SampleW-1:0]       fall_thr[2];
    logic [1:0]               levels;
    logic signed [CountW-1:0] position;
    logic [CountW-1:0]        edge_cnt[2];
    logic [CountW-1:0]        illegal;
    logic [CountW-1:0]        stamp;
    decoder_result_t          expected_q[$];
    int                       errors;

    function new();
      rise_thr = '{HighThrReset, HighThrReset};
      fall_thr = '{LowThrReset, LowThrReset};
      levels   = 2'b00;
      position = '0;
      edge_cnt = '{'0, '0};
      illegal  = '0;
      stamp    = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_threshold(input logic [CfgIdxW-1:0] idx,
                                  input logic [SampleW-1:0] val);
      case (idx)
        CFG_HIGH_THR_A: rise_thr[0] = val;
        CFG_LOW_THR_A:  fall_thr[0] = val;
        CFG_HIGH_THR_B: rise_thr[1] = val;
        CFG_LOW_THR_B:  fall_thr[1] = val;
        default: ;
      endcase
    endfunction

    function void note_sample(input logic ch, input logic [SampleW-1:0] s,
                              input logic [CountW-1:0] t);
      logic [1:0]      mask;
      logic [1:0]      nxt;
      int              step;
      decoder_result_t r;
      mask = ch ? LevelB : LevelA;
      nxt  = levels;
      // Each level only looks at the threshold that can move it.
      if ((levels & mask) != 2'b00) begin
        if (s < fall_thr[ch]) nxt = levels & ~mask;
      end else if (s > rise_thr[ch]) begin
        nxt = levels | mask;
      end
      r.edge_seen = (nxt != levels);
      if (r.edge_seen) begin
        step = GrayStep[{levels, nxt}];
        edge_cnt[ch] = edge_cnt[ch] + 1;
        if (step > 0) position = position + 1;
        else if (step < 0) position = position - 1;
        else illegal = illegal + 1;
        stamp  = t;
        levels = nxt;
      end
      r.position       = position;
      r.phase_bits     = levels;
      r.edges_a        = edge_cnt[0];
      r.edges_b        = edge_cnt[1];
      r.illegal_count  = illegal;
      r.last_edge_time = stamp;
      expected_q.push_back(r);
    endfunction

    function void check_result(input decoder_result_t got);
      decoder_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.phase_bits !== want.phase_bits) begin
        $error("phase_bits: expected %0d, got %0d", want.phase_bits, got.phase_bits);
        errors++;
      end
      if (got.edge_seen !== want.edge_seen) begin
        $error("edge_seen: expected %0d, got %0d", want.edge_seen, got.edge_seen);
        errors++;
      end
      if (got.edges_a !== want.edges_a) begin
        $error("edges_a: expected %0d, got %0d", want.edges_a, got.edges_a);
        errors++;
      end
      if (got.edges_b !== want.edges_b) begin
        $error("edges_b: expected %0d, got %0d", want.edges_b, got.edges_b);
        errors++;
      end
      if (got.illegal_count !== want.illegal_count) begin
        $error("illegal_count: expected %0d, got %0d", want.illegal_count,
               got.illegal_count);
        errors++;
      end
      if (got.last_edge_time !== want.last_edge_time) begin
        $error("last_edge_time: expected %0h, got %0h", want.last_edge_time,
               got.last_edge_time);
        errors++;
      end
    endfunction
  endclass

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic                     in_channel  = 1'b0;
  logic [SampleW-1:0]       in_sample   = '0;
  logic [CountW-1:0]        in_time_now = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [CountW-1:0] out_position;
  logic [1:0]               out_phase_bits;
  logic                     out_edge_seen;
  logic [CountW-1:0]        out_edges_a;
  logic [CountW-1:0]        out_edges_b;
  logic [CountW-1:0]        out_illegal_count;
  logic [CountW-1:0]        out_last_edge_time;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index   = '0;
  logic [SampleW-1:0]       cfg_data    = '0;

  int                 sender_idle_pct = 38;
  int                 recv_idle_pct   = 52;
  int                 quiet_cycles    = 0;
  logic [SampleW-1:0] cur_high[2]     = '{HighThrReset, HighThrReset};
  logic [SampleW-1:0] cur_low[2]      = '{LowThrReset, LowThrReset};

  decoder_scoreboard sb = new();

  hysteresis_quadrature_decoder_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .in_time_now       (in_time_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_phase_bits    (out_phase_bits),
    .out_edge_seen     (out_edge_seen),
    .out_edges_a       (out_edges_a),
    .out_edges_b       (out_edges_b),
    .out_illegal_count (out_illegal_count),
    .out_last_edge_time(out_last_edge_time),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    decoder_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.position       = out_position;
        got.phase_bits     = out_phase_bits;
        got.edge_seen      = out_edge_seen;
        got.edges_a        = out_edges_a;
        got.edges_b        = out_edges_b;
        got.illegal_count  = out_illegal_count;
        got.last_edge_time = out_last_edge_time;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) sb.note_sample(in_channel, in_sample, in_time_now);
      if (cfg_valid && cfg_ready) sb.write_threshold(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic ch, input logic [SampleW-1:0] s,
                             input logic [CountW-1:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_channel  <= ch;
    in_sample   <= s;
    in_time_now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The extra edge first lets the monitor record the last accepted request.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [SampleW-1:0] ha, input logic [SampleW-1:0] la,
                                input logic [SampleW-1:0] hb, input logic [SampleW-1:0] lb);
    drain_results();
    write_reg(CFG_HIGH_THR_A, ha);
    write_reg(CFG_LOW_THR_A, la);
    write_reg(CFG_HIGH_THR_B, hb);
    write_reg(CFG_LOW_THR_B, lb);
    // An index past the last register must leave every threshold alone.
    write_reg(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, NumRegs)),
              SampleW'($urandom_range(SampleMax)));
    cfg_valid <= 1'b0;
    cur_high  = '{ha, hb};
    cur_low   = '{la, lb};
  endtask

  task automatic run_setting(input int p);
    logic [SampleW-1:0] ha, la, hb, lb;
    logic [1:0]         walk;
    logic               fwd;
    logic               ch;
    logic [SampleW-1:0] s;
    int                 r;
    case (p)
      1: begin
        ha = SampleMax;
        la = '0;
        hb = SampleW'($urandom_range(3800, 2048));
        lb = SampleW'($urandom_range(hb, 300));
      end
      2: begin
        ha = SampleW'($urandom_range(SampleMax));
        la = SampleW'($urandom_range(SampleMax));
        hb = SampleW'($urandom_range(SampleMax));
        lb = SampleW'($urandom_range(SampleMax));
      end
      3: begin
        ha = '0;
        la = SampleMax;
        hb = '0;
        lb = SampleMax;
      end
      5: begin
        ha = SampleW'($urandom_range(SampleMax));
        la = ha;
        hb = SampleW'($urandom_range(SampleMax));
        lb = hb;
      end
      default: begin
        ha = SampleW'($urandom_range(3800, 2048));
        la = SampleW'($urandom_range(ha, 300));
        hb = SampleW'($urandom_range(3800, 2048));
        lb = SampleW'($urandom_range(hb, 300));
      end
    endcase
    set_thresholds(ha, la, hb, lb);
    if (p < 2) begin
      sender_idle_pct = 38;
      recv_idle_pct   = 52;
    end else if (p < 4) begin
      sender_idle_pct = 52;
      recv_idle_pct   = 38;
    end else begin
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
    end
    walk = 2'b00;
    fwd  = 1'($urandom_range(1));
    repeat (RandomPerSetting) begin
      r = int'($urandom_range(99));
      if (r < 65) begin
        // Walk the gray sequence so that the position really moves, now and then
        // turning around.
        if ($urandom_range(9) == 0) fwd = !fwd;
        ch = (walk[0] == walk[1]) ? !fwd : fwd;
        if (walk[ch]) begin
          s = (cur_low[ch] != '0) ? SampleW'($urandom_range(cur_low[ch] - 1, 0))
                                  : SampleW'($urandom_range(SampleMax));
        end else begin
          s = (cur_high[ch] != SampleMax)
                ? SampleW'($urandom_range(SampleMax, cur_high[ch] + 1))
                : SampleW'($urandom_range(SampleMax));
        end
        walk[ch] = !walk[ch];
      end else if (r < 85) begin
        ch = 1'($urandom_range(1));
        s  = (cur_low[ch] <= cur_high[ch])
               ? SampleW'($urandom_range(cur_high[ch], cur_low[ch]))
               : SampleW'($urandom_range(SampleMax));
      end else begin
        ch = 1'($urandom_range(1));
        s  = SampleW'($urandom_range(SampleMax));
      end
      send_sample(ch, s, $urandom());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: boundaries, band, both directions of rotation.
    send_sample(1'b0, 12'd2048, 32'h0000_0000);
    send_sample(1'b0, 12'd2049, 32'hffff_ffff);
    send_sample(1'b1, 12'd4095, $urandom());
    send_sample(1'b0, 12'd1024, $urandom());
    send_sample(1'b0, 12'd1500, $urandom());
    send_sample(1'b0, 12'd1023, $urandom());
    send_sample(1'b1, 12'd0, $urandom());
    send_sample(1'b1, 12'd3000, $urandom());
    send_sample(1'b0, 12'd4095, $urandom());
    send_sample(1'b1, 12'd100, $urandom());
    send_sample(1'b0, 12'd5, $urandom());
    send_sample(1'b0, 12'd0, $urandom());
    send_sample(1'b1, 12'd4095, $urandom());

    // A pinned by a high threshold at the top; B with fully crossed thresholds.
    set_thresholds(SampleMax, '0, '0, SampleMax);
    send_sample(1'b0, 12'd4095, $urandom());
    send_sample(1'b1, 12'd4094, $urandom());
    send_sample(1'b1, 12'd1, $urandom());
    send_sample(1'b1, 12'd0, $urandom());

    // A can rise but never fall with a low threshold of zero; B can never rise.
    set_thresholds('0, '0, SampleMax, SampleMax);
    send_sample(1'b0, 12'd1, $urandom());
    send_sample(1'b0, 12'd0, $urandom());
    send_sample(1'b1, 12'd4095, $urandom());
    send_sample(1'b1, 12'd0, $urandom());

    for (int p = 0; p < NumSettings; p++) run_setting(p);

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hqd_pkg.sv
sv/hqd_step.sv
sv/hysteresis_quadrature_decoder_core.sv
tb/tb.sv
